FILE: hdl/rlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rlr_pkg;

   // ramp length counter width
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int CFG_BITS   = 31;
   localparam int DATA_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAG_BITS   = DATA_BITS + 1;
   localparam int STEP_BITS  = MAG_BITS + 1;
   localparam int SPEED_BITS = CFG_BITS + DATA_BITS - FRAC_BITS;
   localparam int PROD_BITS  = CFG_BITS + DATA_BITS;
   localparam int NUM_BITS   = SPEED_BITS + 1;
   localparam int ACC_BITS   = DATA_BITS + COUNT_BITS + 1;
   localparam int ITER_BITS  = $clog2(NUM_BITS);

   localparam logic [CFG_BITS-1:0] PERIOD_RESET   = 31'd655;
   localparam logic [CFG_BITS-1:0] MAX_STEP_RESET = 31'd65536;

   localparam logic signed [STEP_BITS-1:0] STEP_HI = 34'sh0_7FFF_FFFF;
   localparam logic signed [STEP_BITS-1:0] STEP_LO = 34'sh3_8000_0000;
   localparam logic [DATA_BITS-1:0] SAMPLE_HI = 32'h7FFF_FFFF;
   localparam logic [DATA_BITS-1:0] SAMPLE_LO = 32'h8000_0000;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic {
      CSR_SAMPLE_PERIOD = 1'b0,
      CSR_MAX_STEP      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                        func;
      logic signed [DATA_BITS-1:0] start_value;
      logic signed [DATA_BITS-1:0] end_value;
      logic signed [DATA_BITS-1:0] duration;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] sample_value;
      logic                        last;
      logic                        limit_hit;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic tick;
      logic mult;
      logic setup;
      logic div_step;
      logic count;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic active;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_DIV1  = 7'b0001000,
      ST_COUNT = 7'b0010000,
      ST_DIV2  = 7'b0100000,
      ST_STEP  = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

FILE: hdl/rlr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rlr_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_func,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   input  wire rlr_pkg::status_type status,
   output rlr_pkg::cmd_type      cmd
);

   rlr_pkg::state_type state_ff, state_in;
   logic [rlr_pkg::ITER_BITS-1:0] iter_ff, iter_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;

   // a tick may enter in the cycle the waiting item leaves
   assign req_stall  = (state_ff != rlr_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      iter_in  = iter_ff;
      case (state_ff)
         rlr_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_func == rlr_pkg::FUNC_LOAD) begin
                  cmd.capture = 1'b1;
                  state_in    = rlr_pkg::ST_MUL;
               end else begin
                  cmd.tick = status.active;
               end
            end
         end
         rlr_pkg::ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = rlr_pkg::ST_SETUP;
         end
         rlr_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            iter_in   = rlr_pkg::ITER_BITS'(rlr_pkg::NUM_BITS - 1);
            state_in  = rlr_pkg::ST_DIV1;
         end
         rlr_pkg::ST_DIV1: begin
            cmd.div_step = 1'b1;
            if (iter_ff == '0) begin
               state_in = rlr_pkg::ST_COUNT;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         rlr_pkg::ST_COUNT: begin
            cmd.count = 1'b1;
            iter_in   = rlr_pkg::ITER_BITS'(rlr_pkg::MAG_BITS - 1);
            state_in  = rlr_pkg::ST_DIV2;
         end
         rlr_pkg::ST_DIV2: begin
            cmd.div_step = 1'b1;
            if (iter_ff == '0) begin
               state_in = rlr_pkg::ST_STEP;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         rlr_pkg::ST_STEP: begin
            cmd.commit = 1'b1;
            state_in   = rlr_pkg::ST_IDLE;
         end
         default: begin
            state_in = rlr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.tick) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlr_pkg::ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_starts_mult: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_func == rlr_pkg::FUNC_LOAD) |=> state_ff == rlr_pkg::ST_MUL)
      else $error("load item did not start the step calculation");

   a_active_tick_gives_item: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_func == rlr_pkg::FUNC_TICK && status.active) |=> rsp_valid_ff)
      else $error("tick on an active ramp gave no item");

   a_idle_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_func == rlr_pkg::FUNC_TICK && !status.active) |=> !rsp_valid_ff)
      else $error("tick while idle gave an item");

endmodule
`default_nettype wire

FILE: hdl/rlr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rlr_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  wire rlr_pkg::cmd_type      cmd,
   output rlr_pkg::status_type        status,
   input  wire rlr_pkg::req_type      req_data,
   output rlr_pkg::rsp_type           rsp_data,
   input  wire                        csr_write,
   input  wire rlr_pkg::csr_index_type csr_index,
   input  wire [rlr_pkg::CFG_BITS-1:0] csr_wdata
);

   // configuration
   logic [rlr_pkg::CFG_BITS-1:0] period_ff, max_step_ff;

   // load item
   logic signed [rlr_pkg::MAG_BITS-1:0]  diff_ff;
   logic signed [rlr_pkg::DATA_BITS-1:0] dur_ff;
   logic                                 speed_mode_ff;
   logic [rlr_pkg::SPEED_BITS-1:0]       speed_ff;

   // shared restoring divider
   logic [rlr_pkg::NUM_BITS-1:0] rem_ff, num_ff, den_ff;
   logic [rlr_pkg::COUNT_BITS-1:0] count_ff;
   logic hit_ff;

   // ramp state
   logic signed [rlr_pkg::ACC_BITS-1:0]  acc_ff;
   logic signed [rlr_pkg::DATA_BITS-1:0] step_ff;
   logic [rlr_pkg::COUNT_BITS-1:0]       index_ff, total_ff;
   logic                                 clamp_ff;
   rlr_pkg::rsp_type                     rsp_data_ff;

   logic [rlr_pkg::CFG_BITS-1:0]  per;
   logic [rlr_pkg::CFG_BITS-1:0]  dur_pos;
   logic [rlr_pkg::DATA_BITS-1:0] frac;
   logic [rlr_pkg::PROD_BITS-1:0] prod;
   logic [rlr_pkg::MAG_BITS-1:0]  mag;
   logic [rlr_pkg::NUM_BITS-1:0]  setup_num, setup_den;
   logic [rlr_pkg::NUM_BITS:0]    trial, shifted;
   logic [rlr_pkg::NUM_BITS-1:0]  rem_in, num_in;
   logic                          q_over;
   logic [rlr_pkg::COUNT_BITS-1:0] count_in;
   logic [rlr_pkg::MAG_BITS-1:0]  quot;
   logic signed [rlr_pkg::STEP_BITS-1:0] sq, max_s, lim_hi, lim_lo, step_sat;
   logic                          step_hit;
   logic signed [rlr_pkg::ACC_BITS-1:0] acc_in;
   logic [rlr_pkg::DATA_BITS-1:0] sample;
   logic [rlr_pkg::COUNT_BITS-1:0] index_in;
   logic                          last;

   assign per     = (period_ff == '0) ? rlr_pkg::CFG_BITS'(1) : period_ff;
   assign dur_pos = dur_ff[rlr_pkg::CFG_BITS-1:0];
   assign frac    = rlr_pkg::DATA_BITS'(0) - rlr_pkg::DATA_BITS'(dur_ff);
   assign prod    = rlr_pkg::PROD_BITS'(max_step_ff) * rlr_pkg::PROD_BITS'(frac);
   assign mag     = diff_ff[rlr_pkg::MAG_BITS-1] ? rlr_pkg::MAG_BITS'(-diff_ff)
                                                 : rlr_pkg::MAG_BITS'(diff_ff);

   // operands of the sample count division
   always_comb begin
      if (!speed_mode_ff) begin
         setup_num = rlr_pkg::NUM_BITS'((dur_pos < per) ? per : dur_pos);
         setup_den = rlr_pkg::NUM_BITS'(per);
      end else if (mag == '0 || speed_ff == '0) begin
         setup_num = rlr_pkg::NUM_BITS'(1);
         setup_den = rlr_pkg::NUM_BITS'(1);
      end else begin
         // ceiling division: add divisor minus one
         setup_num = rlr_pkg::NUM_BITS'(mag) + rlr_pkg::NUM_BITS'(speed_ff)
                     - rlr_pkg::NUM_BITS'(1);
         setup_den = rlr_pkg::NUM_BITS'(speed_ff);
      end
   end

   // one quotient bit per cycle, quotient shifts into the dividend register
   assign shifted = {rem_ff, num_ff[rlr_pkg::NUM_BITS-1]};
   assign trial   = shifted - {1'b0, den_ff};
   always_comb begin
      if (trial[rlr_pkg::NUM_BITS]) begin
         rem_in = shifted[rlr_pkg::NUM_BITS-1:0];
         num_in = {num_ff[rlr_pkg::NUM_BITS-2:0], 1'b0};
      end else begin
         rem_in = trial[rlr_pkg::NUM_BITS-1:0];
         num_in = {num_ff[rlr_pkg::NUM_BITS-2:0], 1'b1};
      end
   end

   assign q_over   = num_ff[rlr_pkg::NUM_BITS-1:rlr_pkg::COUNT_BITS] != '0;
   assign count_in = q_over ? rlr_pkg::COUNT_MAX : num_ff[rlr_pkg::COUNT_BITS-1:0];

   // sign and limit the step
   assign quot  = num_ff[rlr_pkg::MAG_BITS-1:0];
   assign max_s = rlr_pkg::STEP_BITS'(max_step_ff);
   always_comb begin
      sq = diff_ff[rlr_pkg::MAG_BITS-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      if (speed_mode_ff) begin
         lim_hi = rlr_pkg::STEP_HI;
         lim_lo = rlr_pkg::STEP_LO;
      end else begin
         lim_hi = max_s;
         lim_lo = -max_s;
      end
      step_hit = 1'b1;
      if (sq > lim_hi) begin
         step_sat = lim_hi;
      end else if (sq < lim_lo) begin
         step_sat = lim_lo;
      end else begin
         step_sat = sq;
         step_hit = 1'b0;
      end
   end

   // next sample: accumulate the step, saturate to 32 bits
   assign acc_in   = acc_ff + rlr_pkg::ACC_BITS'(step_ff);
   assign index_in = index_ff + 1'b1;
   assign last     = index_in >= total_ff;
   always_comb begin
      if (acc_in[rlr_pkg::ACC_BITS-1:rlr_pkg::DATA_BITS-1] == '0 ||
          acc_in[rlr_pkg::ACC_BITS-1:rlr_pkg::DATA_BITS-1] == '1) begin
         sample = acc_in[rlr_pkg::DATA_BITS-1:0];
      end else if (acc_in[rlr_pkg::ACC_BITS-1]) begin
         sample = rlr_pkg::SAMPLE_LO;
      end else begin
         sample = rlr_pkg::SAMPLE_HI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= rlr_pkg::PERIOD_RESET;
         max_step_ff <= rlr_pkg::MAX_STEP_RESET;
         acc_ff      <= '0;
         step_ff     <= '0;
         index_ff    <= '0;
         total_ff    <= '0;
         clamp_ff    <= 1'b0;
      end else begin
         if (csr_write && csr_index == rlr_pkg::CSR_SAMPLE_PERIOD) begin
            period_ff <= csr_wdata;
         end
         if (csr_write && csr_index == rlr_pkg::CSR_MAX_STEP) begin
            max_step_ff <= csr_wdata;
         end
         if (cmd.capture) begin
            acc_ff <= rlr_pkg::ACC_BITS'(req_data.start_value);
         end
         if (cmd.commit) begin
            step_ff  <= step_sat[rlr_pkg::DATA_BITS-1:0];
            index_ff <= '0;
            total_ff <= count_ff;
            clamp_ff <= hit_ff | step_hit;
         end
         if (cmd.tick) begin
            acc_ff <= acc_in;
            if (last) begin
               index_ff <= '0;
               total_ff <= '0;
            end else begin
               index_ff <= index_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         diff_ff       <= rlr_pkg::MAG_BITS'(req_data.end_value)
                          - rlr_pkg::MAG_BITS'(req_data.start_value);
         dur_ff        <= req_data.duration;
         speed_mode_ff <= req_data.duration[rlr_pkg::DATA_BITS-1] ||
                          req_data.duration == '0;
      end
      if (cmd.mult) begin
         speed_ff <= prod[rlr_pkg::PROD_BITS-1:rlr_pkg::FRAC_BITS];
      end
      if (cmd.setup) begin
         rem_ff <= '0;
         num_ff <= setup_num;
         den_ff <= setup_den;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
      if (cmd.count) begin
         count_ff <= count_in;
         hit_ff   <= q_over;
         rem_ff   <= '0;
         num_ff   <= {mag, {(rlr_pkg::NUM_BITS - rlr_pkg::MAG_BITS){1'b0}}};
         den_ff   <= rlr_pkg::NUM_BITS'(count_in);
      end
      if (cmd.tick) begin
         rsp_data_ff.sample_value <= sample;
         rsp_data_ff.last         <= last;
         rsp_data_ff.limit_hit    <= clamp_ff;
      end
   end

   assign status.active = total_ff != '0;
   assign rsp_data      = rsp_data_ff;

   a_index_below_total: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) |-> (index_ff < total_ff))
      else $error("sample index reached the ramp length");

   a_commit_arms_ramp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (total_ff != '0 && index_ff == '0))
      else $error("committed ramp has no samples");

endmodule
`default_nettype wire

FILE: hdl/rate_limited_linear_ramp_top.sv
// Linear setpoint ramp generator, one axis, signed Q16.16.
// Input channel req_*: an item with func load carries start, target and
// duration and gives no result; an item with func tick asks for the next
// sample of the current ramp and gives one result item, or none while idle.
// Result channel rsp_*: sample value, last-sample mark and limit flag.
// Configuration channel csr_*: sample_period (index 0) and max_step (index 1),
// always ready; write only while the block is idle.
// A tick's result sits in the output register from the cycle after the tick
// is taken. A load occupies the block until its step is stored, and no item
// is taken before then: one multiply, one setup step, a 48-step restoring
// division for the sample count, a step to saturate the count, a 33-step
// division for the step size and a step to limit and store the step,
// sharing one divider that retires one quotient bit per cycle.
// A new tick may be taken in the cycle its predecessor's result is taken.
// Reset (synchronous) loads the default configuration and leaves no ramp
// active. While the receiver stalls, the result holds and req_stall is raised.
`timescale 1ns / 1ps
`default_nettype none
module rate_limited_linear_ramp_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire rlr_pkg::req_type        req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output rlr_pkg::rsp_type             rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire rlr_pkg::csr_index_type  csr_index,
   input  wire [rlr_pkg::CFG_BITS-1:0]  csr_wdata
);

   rlr_pkg::cmd_type    cmd;
   rlr_pkg::status_type status;
   logic                csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   rlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rlr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire
